@@ rtl/f32exp2_pkg.sv @@
// ============================================================================
// f32exp2_pkg - shared types and constants for the binary32 exp2 pipeline
// Holds the internal number formats, the polynomial coefficients and the
// fixed codes used by the core and its checker.
// ============================================================================
package f32exp2_pkg;

    localparam int EXP_W   = 10;
    localparam int N_TERMS = 6;
    localparam int BIAS    = 127;

    // Edges from the accepting edge to the edge that takes the result word.
    localparam int PIPE_DEPTH = 23;

    localparam logic [31:0] ONE_BITS  = 32'h3f80_0000;
    localparam logic [31:0] INF_BITS  = 32'h7f80_0000;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
    localparam logic [31:0] HI_LIMIT  = 32'h4300_0000;
    localparam logic [31:0] LO_LIMIT  = 32'hc316_0000;

    // Leading coefficient, then the addend of each multiply-add in order.
    localparam logic [31:0] COEF_BITS [N_TERMS+1] = '{
        32'h3920_fdde, 32'h3aaf_9f29, 32'h3c1d_96a6, 32'h3d63_5774,
        32'h3e75_fdee, 32'h3f31_7218, 32'h3f80_0000
    };

    typedef logic signed [EXP_W-1:0] exp_t;

    // Positive normal value: m * 2^(e-23), m[23] set.
    typedef struct packed {
        exp_t        e;
        logic [23:0] m;
    } fnum_t;

    // Reduced argument r, may be subnormal or zero.
    typedef struct packed {
        logic        s;
        exp_t        e;
        logic [23:0] m;
    } rarg_t;

    // Side data that travels with each word through the multiply-add chain.
    typedef struct packed {
        logic              spec;
        logic [31:0]       spec_bits;
        logic signed [8:0] n;
        rarg_t             r;
    } carry_t;

    function automatic fnum_t unpack_const(input logic [31:0] b);
        fnum_t f;
        f.e = exp_t'(b[30:23]) - exp_t'(BIAS);
        f.m = {1'b1, b[22:0]};
        return f;
    endfunction

endpackage

@@ rtl/float32_exp2_core.sv @@
// ============================================================================
// float32_exp2_core - pipelined 2^x on IEEE-754 binary32 words
// Range reduction, six fused multiply-adds and a final scale by 2^n.
// ============================================================================
// Usage: drive x_bits with start high; busy never rises, so a new word is
// taken on every clock edge. The result word for each accepted word is shown
// on result_bits with done high for exactly one cycle. Words leave in the
// same order as they came in. The receiver cannot stall the core and must
// take each word the cycle it is shown. Throughput is one word per cycle;
// the latency is set by the chain of six multiply-add units (three register
// stages each) plus two reduction stages, the input register and two
// scaling stages. NaN inputs return quiet NaN with sign and payload kept,
// plus or minus zero returns 1.0, x >= 128 returns +Inf and x <= -150
// returns +0. All arithmetic rounds to nearest even and keeps subnormal
// results.
module float32_exp2_core
    import f32exp2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] x_bits,
    output logic        done,
    output logic [31:0] result_bits
);

    // The single argument for which x + 0.5 rounds up onto an integer.
    localparam logic [31:0] ROUND_UP_BITS = 32'h3eff_ffff;
    localparam logic [7:0]  HALF_EXP      = 8'd126;
    localparam logic [33:0] HALF_FIX      = 34'h0_0080_0000;
    localparam exp_t        FIX_EXP       = exp_t'(24);
    localparam int          SC_W          = EXP_W + 1;

    // input register
    logic [31:0] x_reg;
    logic        x_valid_reg;

    // reduction, first stage
    logic [30:0]       ax;
    logic              is_nan;
    logic              is_zero;
    logic              is_hi;
    logic              is_lo;
    logic              spec_next;
    logic [31:0]       spec_bits_next;
    logic              small_next;
    logic [7:0]        exp_dist;
    logic [32:0]       mag_x;
    logic [33:0]       x_fix;
    logic [33:0]       t_fix;
    rarg_t             rsmall_next;
    logic signed [8:0] n_next;
    logic              red_valid_reg;
    logic              red_spec_reg;
    logic [31:0]       red_spec_bits_reg;
    logic              red_small_reg;
    logic signed [8:0] red_n_reg;
    rarg_t             red_rsmall_reg;
    logic [23:0]       red_rfix_reg;

    // reduction, second stage: normalize the fixed-point remainder
    logic [23:0] mag_r;
    logic [4:0]  lead_pos;
    logic [4:0]  lead_zeros;
    rarg_t       rfix;
    carry_t      carry_next;
    carry_t      carry_reg;
    logic        carry_valid_reg;

    // multiply-add chain
    logic   chain_valid [N_TERMS+1];
    fnum_t  chain_acc   [N_TERMS+1];
    carry_t chain_carry [N_TERMS+1];

    // scaling
    fnum_t                  acc_f;
    carry_t                 carry_f;
    logic signed [SC_W-1:0] e_sum;
    logic signed [SC_W-1:0] sub_full;
    logic [4:0]             sub_sh_next;
    logic                   sc_valid_reg;
    logic                   sc_spec_reg;
    logic [31:0]            sc_spec_bits_reg;
    logic                   sc_ovf_reg;
    logic                   sc_norm_reg;
    logic [7:0]             sc_efield_reg;
    logic [23:0]            sc_m_reg;
    logic [4:0]             sc_sub_sh_reg;

    // output
    logic [49:0] sub_ext;
    logic [24:0] sub_rnd;
    logic        sub_guard;
    logic        sub_sticky;
    logic [31:0] result_next;
    logic [31:0] result_reg;
    logic        done_reg;

    // ------------------------------------------------------------------
    // Special-case screens and fixed-point split x*2^24 + 2^23 = n*2^24 + R.
    // Arguments below one half in magnitude skip the split: n = 0, r = x, save ROUND_UP_BITS.
    // ------------------------------------------------------------------
    always_comb
    begin
        ax      = x_reg[30:0];
        is_nan  = ax > INF_BITS[30:0];
        is_zero = ax == 31'd0;
        is_hi   = !x_reg[31] && (x_reg >= HI_LIMIT);
        is_lo   = x_reg >= LO_LIMIT;

        spec_next      = is_nan || is_zero || is_hi || is_lo;
        spec_bits_next = 32'd0;
        if (is_nan)
            spec_bits_next = x_reg | QUIET_BIT;
        else if (is_zero)
            spec_bits_next = ONE_BITS;
        else if (is_hi)
            spec_bits_next = INF_BITS;

        small_next = x_reg[30:23] < HALF_EXP;
        exp_dist   = x_reg[30:23] - HALF_EXP;
        mag_x      = {9'b0, 1'b1, x_reg[22:0]} << exp_dist[3:0];
        x_fix      = x_reg[31] ? (34'd0 - {1'b0, mag_x}) : {1'b0, mag_x};
        t_fix      = x_fix + HALF_FIX;

        if (x_reg == ROUND_UP_BITS)
        begin
            // t rounds to 1.0, so n = 1 and r = x - 1 rounds to -0.5
            n_next        = 9'sd1;
            rsmall_next.s = 1'b1;
            rsmall_next.e = -exp_t'(1);
            rsmall_next.m = 24'h80_0000;
        end
        else if (small_next)
        begin
            n_next        = 9'sd0;
            rsmall_next.s = x_reg[31];
            rsmall_next.e = (x_reg[30:23] == 8'd0) ? exp_t'(1 - BIAS)
                                                   : exp_t'(x_reg[30:23]) - exp_t'(BIAS);
            rsmall_next.m = {x_reg[30:23] != 8'd0, x_reg[22:0]};
        end
        else
        begin
            n_next      = t_fix[32:24];
            rsmall_next = '0;
        end
    end

    // Convert the signed 24-bit remainder back to a float.
    always_comb
    begin
        mag_r    = red_rfix_reg[23] ? (24'd0 - red_rfix_reg) : red_rfix_reg;
        lead_pos = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (mag_r[i])
                lead_pos = 5'(i);
        end
        lead_zeros = 5'd23 - lead_pos;
        rfix.s     = red_rfix_reg[23];
        rfix.e     = exp_t'(lead_pos) - FIX_EXP;
        rfix.m     = mag_r << lead_zeros;

        carry_next.spec      = red_spec_reg;
        carry_next.spec_bits = red_spec_bits_reg;
        carry_next.n         = red_n_reg;
        carry_next.r         = red_small_reg ? red_rsmall_reg : rfix;
    end

    // ------------------------------------------------------------------
    // Horner chain: acc = c0, then acc = acc*r + c(k) for each term.
    // ------------------------------------------------------------------
    assign chain_valid[0] = carry_valid_reg;
    assign chain_acc[0]   = unpack_const(COEF_BITS[0]);
    assign chain_carry[0] = carry_reg;

    for (genvar k = 0; k < N_TERMS; k++)
    begin : g_term
        f32exp2_fma u_fma (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .a         (chain_acc[k]),
            .c         (unpack_const(COEF_BITS[k+1])),
            .in_carry  (chain_carry[k]),
            .out_valid (chain_valid[k+1]),
            .y         (chain_acc[k+1]),
            .out_carry (chain_carry[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale by 2^n. The half-step split of the scale is exact on the first
    // multiply, so one rounding on the combined exponent gives the same word.
    // ------------------------------------------------------------------
    always_comb
    begin
        acc_f    = chain_acc[N_TERMS];
        carry_f  = chain_carry[N_TERMS];
        e_sum    = SC_W'(acc_f.e) + SC_W'(carry_f.n);
        sub_full = SC_W'(1 - BIAS) - e_sum;
        if (sub_full > SC_W'(26))
            sub_sh_next = 5'd26;
        else
            sub_sh_next = sub_full[4:0];
    end

    always_comb
    begin
        sub_ext    = {sc_m_reg, 26'b0} >> sc_sub_sh_reg;
        sub_guard  = sub_ext[25];
        sub_sticky = |sub_ext[24:0];
        sub_rnd    = {1'b0, sub_ext[49:26]}
                   + 25'(sub_guard & (sub_sticky | sub_ext[26]));

        if (sc_spec_reg)
            result_next = sc_spec_bits_reg;
        else if (sc_ovf_reg)
            result_next = INF_BITS;
        else if (sc_norm_reg)
            result_next = {1'b0, sc_efield_reg, sc_m_reg[22:0]};
        else
            // a carry into bit 23 lands on the smallest normal, as it should
            result_next = {8'b0, sub_rnd[23:0]};
    end

    // ------------------------------------------------------------------
    // Valid bits: cleared by reset, advance one stage per clock.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg     <= 1'b0;
            red_valid_reg   <= 1'b0;
            carry_valid_reg <= 1'b0;
            sc_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            x_valid_reg     <= start && !busy;
            red_valid_reg   <= x_valid_reg;
            carry_valid_reg <= red_valid_reg;
            sc_valid_reg    <= chain_valid[N_TERMS];
            done_reg        <= sc_valid_reg;
        end
    end

    // Payload registers: no reset, data moves with the valid bits.
    always_ff @(posedge clk)
    begin
        x_reg             <= x_bits;
        red_spec_reg      <= spec_next;
        red_spec_bits_reg <= spec_bits_next;
        red_small_reg     <= small_next || (x_reg == ROUND_UP_BITS);
        red_n_reg         <= n_next;
        red_rsmall_reg    <= rsmall_next;
        red_rfix_reg      <= {~t_fix[23], t_fix[22:0]};
        carry_reg         <= carry_next;
        sc_spec_reg       <= carry_f.spec;
        sc_spec_bits_reg  <= carry_f.spec_bits;
        sc_ovf_reg        <= e_sum > SC_W'(BIAS);
        sc_norm_reg       <= e_sum >= SC_W'(1 - BIAS);
        sc_efield_reg     <= 8'(e_sum + SC_W'(BIAS));
        sc_m_reg          <= acc_f.m;
        sc_sub_sh_reg     <= sub_sh_next;
        result_reg        <= result_next;
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign result_bits = result_reg;

endmodule

@@ rtl/f32exp2_fma.sv @@
// ============================================================================
// f32exp2_fma - three-stage fused multiply-add, y = a*r + c
// Single rounding, ties to even. a and c are positive normal values with
// |a*r| well below c, so the sum stays positive and near the exponent of c.
// ============================================================================
module f32exp2_fma
    import f32exp2_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  fnum_t  a,
    input  fnum_t  c,
    input  carry_t in_carry,
    output logic   out_valid,
    output fnum_t  y,
    output carry_t out_carry
);

    localparam int SH_W = EXP_W + 2;
    localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(48);

    // multiply stage
    logic signed [SH_W-1:0] sh_full;
    logic [47:0]            p_next;
    logic [5:0]             sh_next;
    logic [47:0]            p_reg;
    logic [5:0]             sh_reg;
    logic                   neg_reg;
    carry_t                 mul_carry_reg;
    logic                   mul_valid_reg;

    // align and add stage
    logic [47:0] aligned;
    logic [47:0] drop_mask;
    logic        drop_sticky;
    logic [49:0] c_wide;
    logic [49:0] p_wide;
    logic [49:0] sum_next;
    logic [49:0] sum_reg;
    carry_t      sum_carry_reg;
    logic        sum_valid_reg;

    // normalize and round stage
    logic [23:0] mant;
    logic        guard;
    logic        sticky;
    exp_t        e_adj;
    logic [24:0] rnd;
    fnum_t       y_next;
    fnum_t       y_reg;
    carry_t      y_carry_reg;
    logic        y_valid_reg;

    always_comb
    begin
        p_next  = {24'b0, a.m} * {24'b0, in_carry.r.m};
        sh_full = SH_W'(c.e) - SH_W'(a.e) - SH_W'(in_carry.r.e) - SH_W'(1);
        if (sh_full > SH_MAX)
            sh_next = 6'd48;
        else if (sh_full < 0)
            sh_next = 6'd0;
        else
            sh_next = sh_full[5:0];
    end

    always_comb
    begin
        aligned     = p_reg >> sh_reg;
        drop_mask   = ~({48{1'b1}} << sh_reg);
        drop_sticky = |(p_reg & drop_mask);
        c_wide      = {1'b0, c.m, 25'b0};
        p_wide      = {1'b0, aligned, drop_sticky};
        sum_next    = neg_reg ? (c_wide - p_wide) : (c_wide + p_wide);
    end

    always_comb
    begin
        if (sum_reg[49])
        begin
            mant   = sum_reg[49:26];
            guard  = sum_reg[25];
            sticky = |sum_reg[24:0];
            e_adj  = c.e + exp_t'(1);
        end
        else if (sum_reg[48])
        begin
            mant   = sum_reg[48:25];
            guard  = sum_reg[24];
            sticky = |sum_reg[23:0];
            e_adj  = c.e;
        end
        else
        begin
            mant   = sum_reg[47:24];
            guard  = sum_reg[23];
            sticky = |sum_reg[22:0];
            e_adj  = c.e - exp_t'(1);
        end
        rnd = {1'b0, mant} + 25'(guard & (sticky | mant[0]));
        if (rnd[24])
        begin
            y_next.m = 24'h80_0000;
            y_next.e = e_adj + exp_t'(1);
        end
        else
        begin
            y_next.m = rnd[23:0];
            y_next.e = e_adj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            y_valid_reg   <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            sum_valid_reg <= mul_valid_reg;
            y_valid_reg   <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        sh_reg        <= sh_next;
        neg_reg       <= in_carry.r.s;
        mul_carry_reg <= in_carry;
        sum_reg       <= sum_next;
        sum_carry_reg <= mul_carry_reg;
        y_reg         <= y_next;
        y_carry_reg   <= sum_carry_reg;
    end

    assign out_valid = y_valid_reg;
    assign y         = y_reg;
    assign out_carry = y_carry_reg;

endmodule

@@ rtl/f32exp2_chk.sv @@
// ============================================================================
// f32exp2_chk - port-level checks for float32_exp2_core
// Watches latency, unmatched result strobes and the zero and NaN special-case words.
// ============================================================================
module f32exp2_chk
    import f32exp2_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] x_bits,
    input logic        done,
    input logic [31:0] result_bits
);

    logic accept;
    assign accept = start && !busy;

    // every accepted word leaves after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_DEPTH done)
        else $error("accepted word did not leave after pipeline latency");

    // no strobe without a word accepted at the matching edge
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_DEPTH))
        else $error("result strobe without a matching accepted word");

    // zero in, one out
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && x_bits[30:0] == 31'd0) |-> ##PIPE_DEPTH (result_bits == ONE_BITS))
        else $error("zero argument did not give 1.0");

    // NaN in, quiet NaN out
    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && x_bits[30:23] == 8'hff && x_bits[22:0] != 23'd0)
            |-> ##PIPE_DEPTH (result_bits[30:22] == 9'h1ff))
        else $error("NaN argument did not give a quiet NaN");

endmodule

bind float32_exp2_core f32exp2_chk u_f32exp2_chk (.*);
